FILE: hdl/pwd_pkg.sv
`default_nettype none

package pwd_pkg;

	// Depth of the error window used for the derivative reference.
	localparam int ERROR_WINDOW = 10;

	localparam int CNT_W  = $clog2(ERROR_WINDOW + 1);
	localparam int HEAD_W = (ERROR_WINDOW > 1) ? $clog2(ERROR_WINDOW) : 1;
	localparam int SUM_W  = 32 + CNT_W;

	// Serial divider geometry: the dividend holds a 33 bit magnitude shifted up by 16.
	localparam int DVD_W  = 49;
	localparam int DSR_W  = 32;
	localparam int ITER_W = $clog2(DVD_W + 1);

	// Shared multiplier operand width and the wide accumulators of the output sum.
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int TACC_W = 82;
	localparam int TOT_W  = 66;

	localparam logic [31:0] DT_ONE = 32'h0001_0000;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

	// Configuration register indexes.
	localparam logic [2:0] REG_KP    = 3'd0;
	localparam logic [2:0] REG_KI    = 3'd1;
	localparam logic [2:0] REG_KD    = 3'd2;
	localparam logic [2:0] REG_FLOOR = 3'd3;
	localparam logic [2:0] REG_CEIL  = 3'd4;

	// Output terms, one per gain.
	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_I = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_INT,
		ST_INTEG,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MEAN,
		ST_DER_GO,
		ST_DER_WAIT,
		ST_DERIV,
		ST_PMUL,
		ST_PACC,
		ST_TERM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DSR_W-1:0]  divisor;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// Saturate a wide signed value to 48 bits.
	function automatic logic signed [47:0] sat48(input logic signed [TOT_W-1:0] x);
		logic signed [TOT_W-1:0] hi;
		logic signed [TOT_W-1:0] lo;
		hi = {{(TOT_W-48){MAX48[47]}}, MAX48};
		lo = {{(TOT_W-48){MIN48[47]}}, MIN48};
		if (x > hi) begin
			return MAX48;
		end else if (x < lo) begin
			return MIN48;
		end
		return x[47:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/pwd_divider.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// consumed from its top bit, so a request of N iterations divides the top N
// bits of the dividend word.
module pwd_divider (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire pwd_pkg::div_req_t req,
	output pwd_pkg::div_rsp_t      rsp
);

	logic [pwd_pkg::DSR_W-1:0]  rem_q;
	logic [pwd_pkg::DSR_W-1:0]  dsr_q;
	logic [pwd_pkg::DVD_W-1:0]  dvd_q;
	logic [pwd_pkg::DVD_W-1:0]  quo_q;
	logic [pwd_pkg::ITER_W-1:0] cnt_q;
	logic                       done_q;

	logic [pwd_pkg::DSR_W:0] trial;
	logic [pwd_pkg::DSR_W:0] diff;
	logic                    fits;

	assign trial = {rem_q, dvd_q[pwd_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.iters;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - pwd_pkg::ITER_W'(1);
			done_q <= (cnt_q == pwd_pkg::ITER_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			dvd_q <= req.dividend;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[pwd_pkg::DSR_W-1:0] : trial[pwd_pkg::DSR_W-1:0];
			dvd_q <= {dvd_q[pwd_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[pwd_pkg::DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

FILE: hdl/pid_with_window_derivative.sv
`default_nettype none

// PID controller with a moving-window derivative, all in fixed point.
// Input channel: in_valid/in_stall carries one control step per transaction:
// error_value (Q16.16 signed), time_step (Q16.16 unsigned, zero means 1.0)
// and clear_after. Output channel: out_valid/out_stall carries exactly one
// drive_value (Q32.16 signed, saturated) per input transaction, in order.
// A transaction moves on a rising edge with valid high and stall low.
// A step is taken only in the idle state, so the next step is not taken
// until the previous one has passed through the sequencer. The bit-serial
// divider first forms the window mean (skipped when the window is empty),
// then the derivative; the shared 33x33 multiplier forms the integrator
// product and then the three output terms, each from two partial products.
// The result sits in an output register, so a new step can be taken while the
// previous result waits; if out_stall is still high when the next result is
// ready, the sequencer holds in its final state until the register frees up.
// Reset (arst_n low) clears gains to zero, opens the integrator limits fully,
// and empties the integrator and the error window. Configuration writes go
// through cfg_write_en/cfg_index/cfg_data and take effect at once.
module pid_with_window_derivative (
	input  wire               clk,
	input  wire               arst_n,

	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [31:0] error_value,
	input  wire        [31:0] time_step,
	input  wire               clear_after,

	output logic              out_valid,
	input  wire               out_stall,
	output logic signed [47:0] drive_value,

	input  wire               cfg_write_en,
	input  wire        [2:0]  cfg_index,
	input  wire        [47:0] cfg_data
);

	localparam int W = pwd_pkg::ERROR_WINDOW;

	// Configuration registers.
	logic signed [31:0] kp_q;
	logic signed [31:0] ki_q;
	logic signed [31:0] kd_q;
	logic signed [47:0] floor_q;
	logic signed [47:0] ceil_q;

	// Sequencer and controller state.
	pwd_pkg::state_t state_q;
	pwd_pkg::state_t state_d;

	logic signed [47:0]               integ_q;
	logic signed [pwd_pkg::SUM_W-1:0] sum_q;
	logic [pwd_pkg::CNT_W-1:0]        count_q;
	logic [pwd_pkg::HEAD_W-1:0]       head_q;
	logic signed [31:0]               win_q [W];

	// Per-step working registers.
	logic signed [31:0]                err_q;
	logic [31:0]                       dt_q;
	logic                              clr_q;
	logic                              neg_q;
	logic signed [31:0]                mean_q;
	logic signed [47:0]                deriv_q;
	logic [1:0]                        term_q;
	logic                              part_q;
	logic signed [pwd_pkg::PROD_W-1:0] prod_q;
	logic signed [pwd_pkg::TACC_W-1:0] tacc_q;
	logic signed [pwd_pkg::TOT_W-1:0]  total_q;

	logic               out_valid_q;
	logic signed [47:0] drive_q;

	pwd_pkg::div_req_t div_req;
	pwd_pkg::div_rsp_t div_rsp;

	logic accept;
	logic out_free;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Shared multiplier: operands picked by the sequencer, product registered.
	logic signed [pwd_pkg::MUL_W-1:0] mul_a;
	logic signed [pwd_pkg::MUL_W-1:0] mul_b;
	logic signed [31:0]               gain_sel;
	logic signed [47:0]               opnd_sel;

	always_comb begin
		unique case (term_q)
			pwd_pkg::TERM_P: begin
				gain_sel = kp_q;
				opnd_sel = {{16{err_q[31]}}, err_q};
			end
			pwd_pkg::TERM_I: begin
				gain_sel = ki_q;
				opnd_sel = integ_q;
			end
			default: begin
				gain_sel = kd_q;
				opnd_sel = deriv_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Integrator update: add floor(err*dt / 2^16), saturate, then clamp.
	logic signed [48:0] integ_sum;
	logic signed [47:0] integ_sat;
	logic signed [47:0] integ_new;

	always_comb begin
		integ_sum = {integ_q[47], integ_q} + {prod_q[63], prod_q[63:16]};
		integ_sat = pwd_pkg::sat48({{(pwd_pkg::TOT_W-49){integ_sum[48]}}, integ_sum});
		integ_new = integ_sat;
		if (integ_new < floor_q) begin
			integ_new = floor_q;
		end
		if (integ_new > ceil_q) begin
			integ_new = ceil_q;
		end
	end

	// Window mean division operands.
	logic                     sum_neg;
	logic [pwd_pkg::SUM_W-1:0] sum_mag;
	logic signed [32:0]        mean_q33;
	logic signed [32:0]        mean_new;

	assign sum_neg = sum_q[pwd_pkg::SUM_W-1];
	assign sum_mag = sum_neg ? pwd_pkg::SUM_W'(-sum_q) : pwd_pkg::SUM_W'(sum_q);
	assign mean_q33 = {1'b0, div_rsp.quotient[31:0]};

	always_comb begin
		if (count_q == '0) begin
			mean_new = '0;
		end else if (neg_q) begin
			mean_new = -mean_q33;
		end else begin
			mean_new = mean_q33;
		end
	end

	// Derivative division operands: (err - mean) * 2^16 by dt.
	logic signed [32:0] diff;
	logic        [32:0] diff_mag;
	logic signed [49:0] deriv_q50;
	logic signed [49:0] deriv_new;

	assign diff      = {err_q[31], err_q} - {mean_q[31], mean_q};
	assign diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
	assign deriv_q50 = {1'b0, div_rsp.quotient};
	assign deriv_new = neg_q ? -deriv_q50 : deriv_q50;

	// Window push.
	logic                             win_full;
	logic signed [pwd_pkg::SUM_W-1:0] win_drop;
	logic signed [pwd_pkg::SUM_W-1:0] sum_new;
	logic [pwd_pkg::HEAD_W-1:0]       head_new;

	assign win_full = (count_q >= pwd_pkg::CNT_W'(W));
	assign win_drop = win_full ?
		{{(pwd_pkg::SUM_W-32){win_q[head_q][31]}}, win_q[head_q]} : '0;
	assign sum_new  = sum_q - win_drop + {{(pwd_pkg::SUM_W-32){err_q[31]}}, err_q};
	assign head_new = (head_q == pwd_pkg::HEAD_W'(W - 1)) ? '0 :
		head_q + pwd_pkg::HEAD_W'(1);

	// Next state, multiplier operands and divider requests.
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mul_a    = {err_q[31], err_q};
		mul_b    = {1'b0, dt_q};
		div_req  = '0;

		unique case (state_q)
			pwd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = pwd_pkg::ST_MUL_INT;
				end
			end
			pwd_pkg::ST_MUL_INT: begin
				state_d = pwd_pkg::ST_INTEG;
			end
			pwd_pkg::ST_INTEG: begin
				state_d = (count_q == '0) ? pwd_pkg::ST_MEAN : pwd_pkg::ST_MEAN_GO;
			end
			pwd_pkg::ST_MEAN_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {sum_mag, {(pwd_pkg::DVD_W - pwd_pkg::SUM_W){1'b0}}};
				div_req.divisor  = pwd_pkg::DSR_W'(count_q);
				div_req.iters    = pwd_pkg::ITER_W'(pwd_pkg::SUM_W);
				state_d          = pwd_pkg::ST_MEAN_WAIT;
			end
			pwd_pkg::ST_MEAN_WAIT: begin
				if (div_rsp.done) begin
					state_d = pwd_pkg::ST_MEAN;
				end
			end
			pwd_pkg::ST_MEAN: begin
				state_d = pwd_pkg::ST_DER_GO;
			end
			pwd_pkg::ST_DER_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {diff_mag, 16'h0000};
				div_req.divisor  = dt_q;
				div_req.iters    = pwd_pkg::ITER_W'(pwd_pkg::DVD_W);
				state_d          = pwd_pkg::ST_DER_WAIT;
			end
			pwd_pkg::ST_DER_WAIT: begin
				if (div_rsp.done) begin
					state_d = pwd_pkg::ST_DERIV;
				end
			end
			pwd_pkg::ST_DERIV: begin
				state_d = pwd_pkg::ST_PMUL;
			end
			pwd_pkg::ST_PMUL: begin
				mul_a = {gain_sel[31], gain_sel};
				if (part_q) begin
					mul_b = {{9{opnd_sel[47]}}, opnd_sel[47:24]};
				end else begin
					mul_b = {9'b0, opnd_sel[23:0]};
				end
				state_d = pwd_pkg::ST_PACC;
			end
			pwd_pkg::ST_PACC: begin
				state_d = part_q ? pwd_pkg::ST_TERM : pwd_pkg::ST_PMUL;
			end
			pwd_pkg::ST_TERM: begin
				state_d = (term_q == pwd_pkg::TERM_D) ? pwd_pkg::ST_OUT : pwd_pkg::ST_PMUL;
			end
			pwd_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = pwd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pwd_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state: sequencer, configuration, integrator and window bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pwd_pkg::ST_IDLE;
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			floor_q     <= pwd_pkg::MIN48;
			ceil_q      <= pwd_pkg::MAX48;
			integ_q     <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_write_en) begin
				unique case (cfg_index)
					pwd_pkg::REG_KP:    kp_q    <= cfg_data[31:0];
					pwd_pkg::REG_KI:    ki_q    <= cfg_data[31:0];
					pwd_pkg::REG_KD:    kd_q    <= cfg_data[31:0];
					pwd_pkg::REG_FLOOR: floor_q <= cfg_data;
					pwd_pkg::REG_CEIL:  ceil_q  <= cfg_data;
					default: ;
				endcase
			end

			// A new result replaces the one that leaves in the same cycle.
			if (state_q == pwd_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				pwd_pkg::ST_INTEG: begin
					integ_q <= integ_new;
				end
				pwd_pkg::ST_MEAN: begin
					sum_q  <= sum_new;
					head_q <= head_new;
					if (!win_full) begin
						count_q <= count_q + pwd_pkg::CNT_W'(1);
					end
				end
				pwd_pkg::ST_OUT: begin
					if (out_free && clr_q) begin
						integ_q <= '0;
						sum_q   <= '0;
						count_q <= '0;
						head_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the working step.
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= error_value;
			dt_q  <= (time_step == '0) ? pwd_pkg::DT_ONE : time_step;
			clr_q <= clear_after;
		end

		unique case (state_q)
			pwd_pkg::ST_MEAN_GO: begin
				neg_q <= sum_neg;
			end
			pwd_pkg::ST_MEAN: begin
				mean_q         <= mean_new[31:0];
				win_q[head_q]  <= err_q;
			end
			pwd_pkg::ST_DER_GO: begin
				neg_q <= diff[32];
			end
			pwd_pkg::ST_DERIV: begin
				deriv_q <= pwd_pkg::sat48({{(pwd_pkg::TOT_W-50){deriv_new[49]}}, deriv_new});
				term_q  <= pwd_pkg::TERM_P;
				part_q  <= 1'b0;
				total_q <= '0;
			end
			pwd_pkg::ST_PACC: begin
				if (part_q) begin
					tacc_q <= tacc_q + ({{(pwd_pkg::TACC_W-pwd_pkg::PROD_W){prod_q[pwd_pkg::PROD_W-1]}},
						prod_q} <<< 24);
				end else begin
					tacc_q <= {{(pwd_pkg::TACC_W-pwd_pkg::PROD_W){prod_q[pwd_pkg::PROD_W-1]}}, prod_q};
					part_q <= 1'b1;
				end
			end
			pwd_pkg::ST_TERM: begin
				// Each term is rounded toward minus infinity on its own.
				total_q <= total_q + {{(pwd_pkg::TOT_W-64){tacc_q[79]}}, tacc_q[79:16]};
				part_q  <= 1'b0;
				term_q  <= term_q + 2'd1;
			end
			pwd_pkg::ST_OUT: begin
				if (out_free) begin
					drive_q <= pwd_pkg::sat48(total_q);
				end
			end
			default: ;
		endcase
	end

	pwd_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;

endmodule

`default_nettype wire

FILE: sim/tb_pid_with_window_derivative.sv
`default_nettype none

module tb_pid_with_window_derivative;

	// Arithmetic in the predictor is done at a width where nothing can wrap.
	typedef logic signed [127:0] wide_t;

	// One control step as it crosses the input channel.
	typedef struct packed {
		logic signed [31:0] err;
		logic        [31:0] dt;
		logic               clr;
	} ctrl_step_t;

	localparam int Q1               = 65536;
	localparam int WATCHDOG_LIMIT   = 20000;
	localparam int RECV_HOLD_CYCLES = 600;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] error_value;
	logic        [31:0] time_step;
	logic               clear_after;
	logic               out_valid;
	logic               out_stall;
	logic signed [47:0] drive_value;
	logic               cfg_write_en;
	logic        [2:0]  cfg_index;
	logic        [47:0] cfg_data;

	// Predictor copy of the configuration registers.
	logic signed [31:0] gain_p;
	logic signed [31:0] gain_i;
	logic signed [31:0] gain_d;
	logic signed [47:0] limit_lo;
	logic signed [47:0] limit_hi;

	// Predictor copy of the loop state: integrator and error history.
	logic signed [47:0] integ_acc;
	logic signed [31:0] err_hist [pwd_pkg::ERROR_WINDOW];
	int                 hist_count;
	int                 hist_head;
	wide_t              hist_sum;

	// Drive values still owed by the block, oldest first.
	logic signed [47:0] drive_expected_q [$];

	int fail_count = 0;
	int send_idle_pct;
	int recv_idle_pct;
	// Each increment asks the receiver for one long hold-off.
	int hold_req = 0;

	pid_with_window_derivative i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.error_value  (error_value),
		.time_step    (time_step),
		.clear_after  (clear_after),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_value  (drive_value),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic signed [47:0] clamp48(input wide_t x);
		wide_t hi;
		wide_t lo;
		hi = wide_t'(pwd_pkg::MAX48);
		lo = wide_t'(pwd_pkg::MIN48);
		if (x > hi) begin
			return pwd_pkg::MAX48;
		end
		if (x < lo) begin
			return pwd_pkg::MIN48;
		end
		return x[47:0];
	endfunction

	function automatic void clear_loop_state();
		integ_acc  = '0;
		hist_count = 0;
		hist_head  = 0;
		hist_sum   = '0;
		foreach (err_hist[k]) begin
			err_hist[k] = '0;
		end
	endfunction

	// Advances the predicted loop by one control step and returns the drive value
	// that step must produce. The arithmetic shift gives the floor rounding of
	// every Q16.16 rescale, and signed division truncates toward zero as the
	// mean and the derivative require.
	function automatic logic signed [47:0] predict_drive(input ctrl_step_t s);
		wide_t              err;
		wide_t              dt;
		wide_t              integ;
		wide_t              mean;
		wide_t              deriv;
		wide_t              kp;
		wide_t              ki;
		wide_t              kd;
		wide_t              total;
		logic signed [47:0] drive;
		err = wide_t'(s.err);
		dt  = {96'd0, s.dt};
		if (dt == 0) begin
			dt = wide_t'(Q1);
		end

		// Integrate, saturate, then apply the floor and the ceiling in that order,
		// so the ceiling wins when the limits are crossed.
		integ = wide_t'(clamp48(integ_acc + ((err * dt) >>> 16)));
		if (integ < limit_lo) begin
			integ = wide_t'(limit_lo);
		end
		if (integ > limit_hi) begin
			integ = wide_t'(limit_hi);
		end
		integ_acc = integ[47:0];

		// The derivative is taken against the mean of the errors held in the window.
		mean = '0;
		if (hist_count != 0) begin
			mean = hist_sum / wide_t'(hist_count);
		end
		deriv = wide_t'(clamp48(((err - mean) * Q1) / dt));

		if (hist_count >= pwd_pkg::ERROR_WINDOW) begin
			hist_sum -= wide_t'(err_hist[hist_head]);
		end else begin
			hist_count++;
		end
		err_hist[hist_head] = s.err;
		hist_sum += err;
		hist_head = (hist_head + 1) % pwd_pkg::ERROR_WINDOW;

		kp    = wide_t'(gain_p);
		ki    = wide_t'(gain_i);
		kd    = wide_t'(gain_d);
		total = ((kp * err) >>> 16) + ((ki * integ) >>> 16) + ((kd * deriv) >>> 16);
		drive = clamp48(total);

		// The clear flag acts after the output of this step has been formed.
		if (s.clr) begin
			clear_loop_state();
		end
		return drive;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic ctrl_step_t make_step(input logic [31:0] err, input logic [31:0] dt,
		input logic clr);
		ctrl_step_t s;
		s.err = err;
		s.dt  = dt;
		s.clr = clr;
		return s;
	endfunction

	// Errors lean toward small values so the integrator does not pin at a
	// limit forever, with the extremes and full-range values mixed in.
	function automatic ctrl_step_t random_step(input int clear_pct);
		ctrl_step_t s;
		case ($urandom_range(7))
			0: s.err = 32'h7FFF_FFFF;
			1: s.err = 32'h8000_0000;
			2, 3: s.err = $urandom;
			default: s.err = $urandom_range(0, 20 * Q1) - 10 * Q1;
		endcase
		case ($urandom_range(6))
			0: s.dt = '0;
			1: s.dt = 32'hFFFF_FFFF;
			2: s.dt = $urandom;
			default: s.dt = $urandom_range(1, 4 * Q1);
		endcase
		s.clr = ($urandom_range(99) < clear_pct);
		return s;
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(5))
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3, 4: return $urandom_range(0, 8 * Q1) - 4 * Q1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [47:0] pick_limit();
		int          t;
		logic [47:0] v;
		t = int'($urandom_range(0, 2000 * Q1)) - 1000 * Q1;
		case ($urandom_range(4))
			0: v = pwd_pkg::MAX48;
			1: v = pwd_pkg::MIN48;
			2: v = 48'({$urandom, $urandom});
			default: v = 48'(t);
		endcase
		return v;
	endfunction

	// A register write takes effect at the rising edge after the write enable
	// goes high; the predictor copy is updated at the same time, while no
	// transaction is in flight.
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= data;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			pwd_pkg::REG_KP: gain_p = data[31:0];
			pwd_pkg::REG_KI: gain_i = data[31:0];
			pwd_pkg::REG_KD: gain_d = data[31:0];
			pwd_pkg::REG_FLOOR: limit_lo = data;
			pwd_pkg::REG_CEIL: limit_hi = data;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
		input logic [31:0] kd, input logic [47:0] lo, input logic [47:0] hi);
		write_reg(pwd_pkg::REG_KP, {{16{kp[31]}}, kp});
		write_reg(pwd_pkg::REG_KI, {{16{ki[31]}}, ki});
		write_reg(pwd_pkg::REG_KD, {{16{kd[31]}}, kd});
		write_reg(pwd_pkg::REG_FLOOR, lo);
		write_reg(pwd_pkg::REG_CEIL, hi);
	endtask

	// Offers one control step and returns once the block has taken it. An
	// optional idle gap comes first, during which the payload carries noise
	// with valid low. Valid stays high after the transaction until the next
	// falling edge, where it is either reused for the next step or lowered.
	task automatic send_step(input ctrl_step_t s);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = ($urandom_range(9) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 8);
		end
		repeat (gap) begin
			@(negedge clk);
			in_valid    <= 1'b0;
			error_value <= $urandom;
			time_step   <= $urandom;
			clear_after <= 1'($urandom_range(1));
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		error_value <= s.err;
		time_step   <= s.dt;
		clear_after <= s.clr;
		do @(posedge clk); while (in_stall);
		drive_expected_q.push_back(predict_drive(s));
	endtask

	// Stops offering steps and waits until every owed drive value has been
	// taken, plus a short margin so the block is surely back in idle.
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (drive_expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Straight out of reset all gains are zero, so every drive value is zero
	// whatever the error, the time step or the clear flag.
	task automatic test_reset_state();
		send_step(make_step(32'h7FFF_FFFF, 32'h0, 1'b0));
		send_step(make_step(32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
		send_step(make_step(32'h0, 32'h1, 1'b0));
		wait_results_drained();
	endtask

	// Extreme gains against extreme errors and time steps: a zero time step,
	// the smallest one (which saturates the derivative), the largest one, a
	// clear in the middle and a step on the emptied window right after it.
	task automatic test_extreme_steps();
		load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, pwd_pkg::MIN48,
			pwd_pkg::MAX48);
		send_step(make_step(32'h7FFF_FFFF, 32'h0, 1'b0));
		send_step(make_step(32'h8000_0000, 32'h1, 1'b0));
		send_step(make_step(32'h0, 32'hFFFF_FFFF, 1'b0));
		send_step(make_step(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		send_step(make_step(32'h8000_0000, pwd_pkg::DT_ONE, 1'b1));
		send_step(make_step(32'h1234_5678, 32'h1, 1'b0));
		wait_results_drained();
	endtask

	// A floor above the ceiling must leave the integrator at the ceiling.
	// Writes to indexes past the last register must change nothing.
	// Tight limits with a run longer than the window then push the integrator
	// into both clamps while the oldest errors start dropping out.
	task automatic test_limits_and_window();
		int k;
		write_reg(pwd_pkg::REG_CEIL + 3'd1, 48'({$urandom, $urandom}));
		write_reg(pwd_pkg::REG_CEIL + 3'd3, 48'({$urandom, $urandom}));
		load_settings(32'h0, pwd_pkg::DT_ONE, 32'h0, 48'(100 * Q1), 48'(-100 * Q1));
		send_step(make_step(Q1, 32'h0, 1'b0));
		send_step(make_step(-Q1, 32'h0, 1'b0));
		wait_results_drained();

		load_settings(pwd_pkg::DT_ONE, pwd_pkg::DT_ONE, -Q1, 48'(-3 * Q1), 48'(3 * Q1));
		for (k = 0; k < 13; k++) begin
			send_step(make_step((k % 6 < 3) ? 2 * Q1 : -(3 * Q1 / 2) - k,
				(k % 3 == 0) ? 32'h0 : Q1 / 2 + k * 4096, 1'b0));
		end
		wait_results_drained();
	endtask

	// Random control steps in phases. Every phase loads a fresh random setting
	// and uses its own clear rate: mostly long uninterrupted runs that fill and
	// cycle the error window, sometimes frequent clears as noise.
	task automatic test_random_traffic(input int n_items, input int sender_pct,
		input int receiver_pct);
		int          sent;
		int          phase_len;
		int          clear_pct;
		logic [47:0] lo;
		logic [47:0] hi;
		logic [47:0] tmp;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		sent = 0;
		while (sent < n_items) begin
			lo = pick_limit();
			hi = pick_limit();
			if ($urandom_range(3) != 0 && $signed(lo) > $signed(hi)) begin
				tmp = lo;
				lo  = hi;
				hi  = tmp;
			end
			load_settings(pick_gain(), pick_gain(), pick_gain(), lo, hi);
			if ($urandom_range(3) == 0) begin
				write_reg(pwd_pkg::REG_CEIL + 3'd1 + 3'($urandom_range(2)),
					48'({$urandom, $urandom}));
			end
			case ($urandom_range(3))
				0: clear_pct = 30;
				1: clear_pct = 5;
				default: clear_pct = 1;
			endcase
			phase_len = $urandom_range(20, 80);
			repeat (phase_len) send_step(random_step(clear_pct));
			sent += phase_len;
			wait_results_drained();
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering steps back to back, so the output register and the sequencer
	// fill up and the block stalls its input.
	task automatic test_receiver_hold();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req++;
		repeat (8) send_step(random_step(5));
		wait_results_drained();
	endtask

	// ------------------------------------------------------------------
	// Receiver, checker and watchdog
	// ------------------------------------------------------------------

	// The receiver stall is drawn per cycle from the current idle rate unless
	// a hold-off is running, which this process counts down itself.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = RECV_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Every output transaction is matched against the oldest owed drive value.
	always @(posedge clk) begin : check_drive
		logic signed [47:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_expected_q.size() == 0) begin
				$error("drive_value: transaction with nothing expected, actual %0d",
					drive_value);
				fail_count++;
			end else begin
				want = drive_expected_q.pop_front();
				if (drive_value !== want) begin
					$error("drive_value mismatch: expected %0d, actual %0d", want, drive_value);
					fail_count++;
				end
			end
		end
	end

	// A run in which no transaction moves on either channel for this long is
	// hung.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		error_value    = '0;
		time_step      = '0;
		clear_after    = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;

		// The predictor starts from the reset values of the block.
		gain_p   = '0;
		gain_i   = '0;
		gain_d   = '0;
		limit_lo = pwd_pkg::MIN48;
		limit_hi = pwd_pkg::MAX48;
		clear_loop_state();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_extreme_steps();
		test_limits_and_window();
		test_random_traffic(350, 33, 76);
		test_random_traffic(350, 76, 33);
		test_random_traffic(350, 0, 0);
		test_receiver_hold();

		// Leave time for any stray transaction to show up before the verdict.
		wait_results_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
